/* hw/rtl/directory_name_lru_cache_defines.svh */
// assertion macros for the directory name cache
// used by the top level only; needs clk and rst in scope
`ifndef DIRECTORY_NAME_LRU_CACHE_DEFINES_SVH
`define DIRECTORY_NAME_LRU_CACHE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DNLC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dnlc assertion failed");
`define DNLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dnlc assertion failed");
`else
`define DNLC_ASSERT(lbl, ante, cons)
`define DNLC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/dnlc_pkg.sv */
// shared types and constants for the directory name cache
// no dependencies
package dnlc_pkg;
  localparam int CAPACITY    = 256;
  localparam int IDX_W       = 8;
  localparam int MAX_NAME    = 255;
  localparam int CHUNK_BYTES = 8;
  localparam int NAME_WORDS  = 32;
  localparam int WORD_W      = 5;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ENTER  = 2'd1;
  localparam logic [1:0] REQ_PVNODE = 2'd2;
  localparam logic [1:0] REQ_PMOUNT = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NEG    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic [31:0] dir;
    logic [31:0] tgt;
    logic [15:0] mount;
    logic [7:0]  len;
    logic [7:0]  rank;
  } meta_t;
endpackage

/* hw/rtl/dnlc_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module dnlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/dnlc_name_buf.sv */
// collects the incoming name, one chunk per beat, into 32 words
// depends on dnlc_pkg
module dnlc_name_buf import dnlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [63:0]       chunk,
  input  logic [3:0]        clen,
  input  logic              clr,
  input  logic [WORD_W-1:0] rd_addr,
  output logic [63:0]       rd_word,
  output logic [7:0]        name_len,
  output logic              too_long
);
  logic [63:0]           words [NAME_WORDS];
  logic [NAME_WORDS-1:0] word_ok;
  logic [7:0]            len;
  logic                  tl;
  logic [3:0]            clen_sat;
  logic [7:0]            room;
  logic                  over;
  logic [3:0]            n;
  logic [63:0]           masked;
  logic [127:0]          shifted;
  logic [WORD_W-1:0]     lo;
  logic [WORD_W-1:0]     hi;
  logic [2:0]            off;

  always_comb begin
    clen_sat = (clen > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : clen;
    room     = 8'(MAX_NAME) - len;
    over     = {4'b0, clen_sat} > room;
    n        = over ? room[3:0] : clen_sat;
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < n) ? chunk[b*8 +: 8] : 8'd0;
    end
    off     = len[2:0];
    shifted = {64'd0, masked} << {off, 3'b000};
    lo      = len[7:3];
    hi      = lo + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      word_ok <= '0;
      len     <= '0;
      tl      <= 1'b0;
    end else if (wr_en) begin
      word_ok[lo] <= 1'b1;
      if (lo != 5'(NAME_WORDS-1)) begin
        word_ok[hi] <= 1'b1;
      end
      len <= len + {4'b0, n};
      if (over) begin
        tl <= 1'b1;
      end
    end
  end

  // bytes below the offset already hold the name; the word above holds none yet
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < 8; k++) begin
        if (3'(k) >= off) begin
          words[lo][k*8 +: 8] <= shifted[k*8 +: 8];
        end
      end
      if (lo != 5'(NAME_WORDS-1)) begin
        words[hi] <= shifted[127:64];
      end
    end
  end

  assign rd_word  = word_ok[rd_addr] ? words[rd_addr] : 64'd0;
  assign name_len = len;
  assign too_long = tl;
endmodule

/* hw/rtl/directory_name_lru_cache.sv */
// Directory name cache, 256 entries, LRU replacement. A request arrives as
// name chunks; each beat without name_last is taken while the sequencer is
// idle, the last beat starts a walk by a single sequencer over the entry
// store, one entry read at a time through one metadata memory port. A key
// search reads the entries in turn and, on a candidate, compares up to 32 name
// words; every removal or recency move runs a rank sweep over all entries; an
// insert copies the 32 name words. Purges scan every entry and run a rank sweep
// per removed entry. The result waits in an output register; a new request is
// taken once the sequencer is back to idle.
module directory_name_lru_cache import dnlc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] dir_id,
  input  logic [31:0] target_id,
  input  logic [15:0] mount_id,
  input  logic [63:0] name_chunk,
  input  logic [3:0]  chunk_len,
  input  logic        name_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] target_out,
  output logic [8:0]  entries_in_use
);
`include "directory_name_lru_cache_defines.svh"

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_F_RD  = 5'd2;
  localparam logic [4:0] S_F_EV  = 5'd3;
  localparam logic [4:0] S_C_RD  = 5'd4;
  localparam logic [4:0] S_C_EV  = 5'd5;
  localparam logic [4:0] S_MISS  = 5'd6;
  localparam logic [4:0] S_HIT   = 5'd7;
  localparam logic [4:0] S_D_RD  = 5'd8;
  localparam logic [4:0] S_D_EV  = 5'd9;
  localparam logic [4:0] S_TOUCH = 5'd10;
  localparam logic [4:0] S_E_RD  = 5'd11;
  localparam logic [4:0] S_E_EV  = 5'd12;
  localparam logic [4:0] S_FREE  = 5'd13;
  localparam logic [4:0] S_COPY  = 5'd14;
  localparam logic [4:0] S_P_RD  = 5'd15;
  localparam logic [4:0] S_P_EV  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  localparam logic [1:0] RET_TOUCH = 2'd0;
  localparam logic [1:0] RET_PURGE = 2'd1;
  localparam logic [1:0] RET_EVICT = 2'd2;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY-1);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NAME_WORDS-1);

  logic [4:0]          state;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    jdx;
  logic [WORD_W-1:0]   w;
  logic [IDX_W-1:0]    slot;
  logic [7:0]          r_ref;
  logic [1:0]          ret;
  logic [1:0]          req_q;
  logic [31:0]         dir_q;
  logic [31:0]         tgt_q;
  logic [15:0]         mnt_q;
  meta_t               hit;
  logic [1:0]          res_status;
  logic [31:0]         res_tout;
  logic [8:0]          count;
  logic [8:0]          limit;
  logic [CAPACITY-1:0] valid;

  logic                in_acc;
  logic                load;
  logic                meta_we;
  logic [IDX_W-1:0]    meta_waddr;
  meta_t               meta_wdata;
  logic [IDX_W-1:0]    meta_raddr;
  logic [95:0]         meta_rraw;
  meta_t               rd;
  logic                name_we;
  logic [63:0]         name_rdata;
  logic [63:0]         buf_word;
  logic [7:0]          buf_len;
  logic                buf_tl;
  logic                evict;
  logic                pmatch;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load     = (state == S_DONE) && (!out_valid || !out_stall);
  assign rd       = meta_t'(meta_rraw);
  assign evict    = (count != 9'd0) && ((count >= limit) || (count >= 9'(CAPACITY)));
  assign pmatch   = (req_q == REQ_PVNODE) ? ((rd.dir == tgt_q) || (rd.tgt == tgt_q))
                                          : ((rd.dir != 32'd0) && (rd.mount == mnt_q));

  dnlc_name_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc),
    .chunk    (name_chunk),
    .clen     (chunk_len),
    .clr      (load),
    .rd_addr  (w),
    .rd_word  (buf_word),
    .name_len (buf_len),
    .too_long (buf_tl)
  );

  dnlc_ram #(.WIDTH(96), .DEPTH(CAPACITY)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rraw)
  );

  dnlc_ram #(.WIDTH(64), .DEPTH(CAPACITY*NAME_WORDS)) u_name (
    .clk   (clk),
    .we    (name_we),
    .waddr ({slot, w}),
    .wdata (buf_word),
    .raddr ({idx, w}),
    .rdata (name_rdata)
  );

  always_comb begin
    meta_raddr = ((state == S_D_RD) || (state == S_D_EV)) ? jdx : idx;
    meta_we    = 1'b0;
    meta_waddr = idx;
    meta_wdata = hit;
    name_we    = (state == S_COPY);
    case (state)
      S_HIT: begin
        if (req_q == REQ_ENTER) begin
          meta_we        = 1'b1;
          meta_wdata.tgt = tgt_q;
        end
      end
      S_D_EV: begin
        meta_waddr = jdx;
        meta_wdata = rd;
        meta_wdata.rank = rd.rank - 8'd1;
        meta_we    = valid[jdx] && (rd.rank > r_ref);
      end
      S_TOUCH: begin
        meta_we         = 1'b1;
        meta_wdata.rank = 8'(count - 9'd1);
      end
      S_FREE: begin
        meta_we    = !valid[idx];
        meta_wdata = '{dir: dir_q, tgt: tgt_q, mount: mnt_q, len: buf_len,
                       rank: count[7:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      limit     <= 9'(CAPACITY);
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && name_last) begin
            res_status <= (req_type == REQ_LOOKUP) ? ST_ABSENT : ST_DONE;
            res_tout   <= 32'd0;
            state      <= S_START;
          end
        end
        S_START: begin
          idx <= '0;
          if ((req_q == REQ_PVNODE) || (req_q == REQ_PMOUNT)) begin
            state <= S_P_RD;
          end else if (buf_tl) begin
            state <= S_DONE;
          end else begin
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_EV;
        S_F_EV: begin
          if (valid[idx] && (rd.dir == dir_q) && (rd.len == buf_len)) begin
            w     <= '0;
            state <= S_C_RD;
          end else if (idx == LAST_IDX) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_F_RD;
          end
        end
        S_C_RD: state <= S_C_EV;
        S_C_EV: begin
          if (name_rdata == buf_word) begin
            if (w == LAST_WORD) begin
              state <= S_HIT;
            end else begin
              w     <= w + 5'd1;
              state <= S_C_RD;
            end
          end else if (idx == LAST_IDX) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_F_RD;
          end
        end
        S_MISS: begin
          idx <= '0;
          if (req_q == REQ_LOOKUP) begin
            state <= S_DONE;
          end else if (evict) begin
            state <= S_E_RD;
          end else begin
            state <= S_FREE;
          end
        end
        S_HIT: begin
          if (req_q == REQ_LOOKUP) begin
            r_ref <= hit.rank;
            ret   <= RET_TOUCH;
            jdx   <= '0;
            state <= S_D_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_D_RD: state <= S_D_EV;
        S_D_EV: begin
          if (jdx == LAST_IDX) begin
            case (ret)
              RET_TOUCH: state <= S_TOUCH;
              RET_PURGE: begin
                if (idx == LAST_IDX) begin
                  state <= S_DONE;
                end else begin
                  idx   <= idx + 8'd1;
                  state <= S_P_RD;
                end
              end
              default: begin
                idx   <= '0;
                state <= S_FREE;
              end
            endcase
          end else begin
            jdx   <= jdx + 8'd1;
            state <= S_D_RD;
          end
        end
        S_TOUCH: begin
          res_status <= (hit.tgt != 32'd0) ? ST_FOUND : ST_NEG;
          res_tout   <= hit.tgt;
          state      <= S_DONE;
        end
        S_E_RD: state <= S_E_EV;
        S_E_EV: begin
          if (valid[idx] && (rd.rank == 8'd0)) begin
            valid[idx] <= 1'b0;
            count      <= count - 9'd1;
            r_ref      <= 8'd0;
            ret        <= RET_EVICT;
            jdx        <= '0;
            state      <= S_D_RD;
          end else if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_FREE;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_E_RD;
          end
        end
        S_FREE: begin
          if (!valid[idx]) begin
            valid[idx] <= 1'b1;
            count      <= count + 9'd1;
            slot       <= idx;
            w          <= '0;
            state      <= S_COPY;
          end else if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 8'd1;
          end
        end
        S_COPY: begin
          if (w == LAST_WORD) begin
            state <= S_DONE;
          end else begin
            w <= w + 5'd1;
          end
        end
        S_P_RD: state <= S_P_EV;
        S_P_EV: begin
          if (valid[idx] && pmatch) begin
            valid[idx] <= 1'b0;
            count      <= count - 9'd1;
            r_ref      <= rd.rank;
            ret        <= RET_PURGE;
            jdx        <= '0;
            state      <= S_D_RD;
          end else if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 8'd1;
            state <= S_P_RD;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && name_last) begin
      req_q      <= req_type;
      dir_q      <= dir_id;
      tgt_q      <= target_id;
      mnt_q      <= mount_id;
    end
    if (state == S_F_EV) begin
      hit <= rd;
    end
    if (load) begin
      status         <= res_status;
      target_out     <= res_tout;
      entries_in_use <= count;
    end
  end

  `DNLC_ASSERT(a_count_max, 1'b1, count <= 9'(CAPACITY))
  `DNLC_ASSERT(a_count_valid, 1'b1, $countones(valid) == 32'(count))
  `DNLC_ASSERT_NXT(a_copy_slot, state == S_COPY, valid[slot])
endmodule

/* tb/sv/directory_name_lru_cache_tb.sv */
// self-checking testbench for the directory name cache with lru replacement
// needs dnlc_pkg and directory_name_lru_cache; predicts every result itself
module directory_name_lru_cache_tb;
  import dnlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] dir;
    logic [31:0] tgt;
    logic [15:0] mnt;
    logic [63:0] chunk;
    logic [3:0]  clen;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] tout;
    logic [8:0]  cnt;
  } reply_t;

  typedef struct {
    beat_t  b;
    int     reps;
    logic [3:0] rep_len;
    logic   typed;
    reply_t r;
  } row_t;

  typedef struct {
    bit          v;
    logic [31:0] dir;
    logic [31:0] tgt;
    logic [15:0] mnt;
    int          len;
    logic [63:0] w [NAME_WORDS];
    int          rank;
  } slot_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [31:0] dir_id = '0;
  logic [31:0] target_id = '0;
  logic [15:0] mount_id = '0;
  logic [63:0] name_chunk = '0;
  logic [3:0]  chunk_len = '0;
  logic        name_last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [31:0] target_out;
  logic [8:0]  entries_in_use;

  directory_name_lru_cache DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .dir_id(dir_id), .target_id(target_id), .mount_id(mount_id),
    .name_chunk(name_chunk), .chunk_len(chunk_len), .name_last(name_last),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .target_out(target_out), .entries_in_use(entries_in_use)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // mirror of the cache contents
  slot_t       store [CAPACITY];
  int          slot_count;
  int          limit_mirror;
  logic [63:0] acc [NAME_WORDS];
  int          acc_len;
  bit          acc_long;

  reply_t      pending_q [$];
  int          errors;
  int          beats_sent;
  bit          quiet;
  longint      cycles = 0;
  row_t        rows [$];

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int find_slot(logic [31:0] dir);
    int w;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!store[i].v || store[i].dir != dir || store[i].len != acc_len) continue;
      for (w = 0; w < NAME_WORDS; w++)
        if (store[i].w[w] != acc[w]) break;
      if (w == NAME_WORDS) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int e);
    store[e].v = 0;
    for (int i = 0; i < CAPACITY; i++)
      if (store[i].v && store[i].rank > store[e].rank) store[i].rank--;
    slot_count--;
  endfunction

  function automatic void promote_slot(int e);
    for (int i = 0; i < CAPACITY; i++)
      if (store[i].v && store[i].rank > store[e].rank) store[i].rank--;
    store[e].rank = slot_count - 1;
  endfunction

  function automatic void insert_key(logic [31:0] dir, logic [31:0] tgt, logic [15:0] mnt);
    int e;
    int i;
    e = find_slot(dir);
    if (e >= 0) begin
      store[e].tgt = tgt;
      return;
    end
    if (slot_count > 0 && (slot_count >= limit_mirror || slot_count >= CAPACITY)) begin
      for (i = 0; i < CAPACITY; i++)
        if (store[i].v && store[i].rank == 0) begin
          drop_slot(i);
          break;
        end
    end
    for (i = 0; i < CAPACITY; i++)
      if (!store[i].v) break;
    if (i == CAPACITY) return;
    store[i].v = 1;
    store[i].dir = dir;
    store[i].tgt = tgt;
    store[i].mnt = mnt;
    store[i].len = acc_len;
    store[i].w = acc;
    store[i].rank = slot_count;
    slot_count++;
  endfunction

  function automatic void cache_step(beat_t b, output bit has, output reply_t r);
    int clen;
    int e;
    clen = (b.clen > CHUNK_BYTES) ? CHUNK_BYTES : b.clen;
    has = 0;
    r = '{ST_DONE, 32'd0, 9'd0};
    for (int k = 0; k < clen; k++) begin
      if (acc_len >= MAX_NAME) begin
        acc_long = 1;
        break;
      end
      acc[acc_len / 8] |= 64'(b.chunk[8*k +: 8]) << (8 * (acc_len % 8));
      acc_len++;
    end
    if (!b.last) return;
    has = 1;
    case (b.req)
      REQ_LOOKUP: begin
        r.st = ST_ABSENT;
        if (!acc_long) begin
          e = find_slot(b.dir);
          if (e >= 0) begin
            promote_slot(e);
            r.tout = store[e].tgt;
            r.st = (r.tout != 0) ? ST_FOUND : ST_NEG;
          end
        end
      end
      REQ_ENTER: begin
        if (!acc_long) insert_key(b.dir, b.tgt, b.mnt);
      end
      REQ_PVNODE: begin
        for (int i = 0; i < CAPACITY; i++)
          if (store[i].v && (store[i].dir == b.tgt || store[i].tgt == b.tgt)) drop_slot(i);
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++)
          if (store[i].v && store[i].dir != 0 && store[i].mnt == b.mnt) drop_slot(i);
      end
    endcase
    for (int w = 0; w < NAME_WORDS; w++) acc[w] = '0;
    acc_len = 0;
    acc_long = 0;
    r.cnt = 9'(slot_count);
  endfunction

  // returns the predicted reply so the directed table can check typed values
  task automatic send_beat(beat_t b, output bit has, output reply_t r);
    if (!quiet) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid   <= 1;
    req_type   <= b.req;
    dir_id     <= b.dir;
    target_id  <= b.tgt;
    mount_id   <= b.mnt;
    name_chunk <= b.chunk;
    chunk_len  <= b.clen;
    name_last  <= b.last;
    do @(posedge clk); while (in_stall);
    cache_step(b, has, r);
    if (has) pending_q.push_back(r);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    cfg_we   <= 1;
    cfg_data <= 9'(v);
    @(posedge clk);
    cfg_we <= 0;
    limit_mirror = v;
  endtask

  // sends one request as a run of chunks; fields of non-last beats are noise
  task automatic issue(logic [1:0] req, logic [31:0] dir, logic [31:0] tgt,
                       logic [15:0] mnt, byte nm [$]);
    int     pos;
    int     take;
    bit     has;
    reply_t r;
    beat_t  b;
    pos = 0;
    forever begin
      take = $urandom_range(0, 8);
      if (take > nm.size() - pos) take = nm.size() - pos;
      b.chunk = {$urandom, $urandom};
      for (int k = 0; k < take; k++) b.chunk[8*k +: 8] = nm[pos + k];
      b.clen = (take == 8) ? 4'($urandom_range(8, 15)) : 4'(take);
      pos += take;
      b.last = (pos == nm.size()) && ($urandom_range(3) != 0);
      if (b.last) begin
        b.req = req; b.dir = dir; b.tgt = tgt; b.mnt = mnt;
      end else begin
        b.req = 2'($urandom); b.dir = $urandom; b.tgt = $urandom; b.mnt = 16'($urandom);
      end
      send_beat(b, has, r);
      if (b.last) break;
    end
  endtask

  task automatic random_phase(int budget);
    logic [31:0] dirs [6];
    logic [15:0] mnts [3];
    byte         names [6][$];
    byte         nm [$];
    logic [31:0] tgt;
    int          pick;
    int          stop;
    stop = beats_sent + budget;
    dirs[0] = 0;
    dirs[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) dirs[i] = $urandom;
    for (int i = 0; i < 3; i++) mnts[i] = 16'($urandom);
    for (int i = 0; i < 6; i++) begin
      names[i] = {};
      repeat ($urandom_range(0, 20)) names[i].push_back(byte'($urandom));
    end
    while (beats_sent < stop) begin
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) begin
        nm = {};
        repeat ($urandom_range(250, 300)) nm.push_back(byte'($urandom));
      end else
        nm = names[$urandom_range(5)];
      case ($urandom_range(3))
        0: tgt = 0;
        1: tgt = dirs[$urandom_range(5)];
        default: tgt = $urandom;
      endcase
      if (pick < 42)
        issue(REQ_LOOKUP, dirs[$urandom_range(5)], $urandom, 16'($urandom), nm);
      else if (pick < 85)
        issue(REQ_ENTER, dirs[$urandom_range(5)], tgt, mnts[$urandom_range(2)], nm);
      else if (pick < 93)
        issue(REQ_PVNODE, $urandom, tgt, 16'($urandom), nm);
      else
        issue(REQ_PMOUNT, $urandom, $urandom, mnts[$urandom_range(2)], nm);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("directory_name_lru_cache_tb: FAIL");
      $finish;
    end
  end

  // result side: random stall, compare each beat with the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (rst)
      out_stall <= 0;
    else
      out_stall <= !quiet && ($urandom_range(99) < 10);
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0)
        report("result beat with nothing expected");
      else begin
        want = pending_q.pop_front();
        if (status !== want.st)
          report($sformatf("status %0d, expected %0d", status, want.st));
        if (target_out !== want.tout)
          report($sformatf("target_out %h, expected %h", target_out, want.tout));
        if (entries_in_use !== want.cnt)
          report($sformatf("entries_in_use %0d, expected %0d", entries_in_use, want.cnt));
      end
    end
  end

  function automatic row_t mk(logic [1:0] req, logic [31:0] dir, logic [31:0] tgt,
                              logic [15:0] mnt, logic [63:0] chunk, logic [3:0] clen,
                              int reps, logic [3:0] rep_len,
                              logic [1:0] st, logic [31:0] tout, logic [8:0] cnt);
    row_t x;
    x.b = '{req, dir, tgt, mnt, chunk, clen, 1'b1};
    x.reps = reps;
    x.rep_len = rep_len;
    x.typed = 1;
    x.r = '{st, tout, cnt};
    return x;
  endfunction

  initial begin
    localparam logic [63:0] ONES = '1;
    bit          has;
    reply_t      r;
    beat_t       b;
    byte         nm [$];
    logic [15:0] fill_mnt;
    int          lims [5];

    errors = 0;
    beats_sent = 0;
    quiet = 0;
    slot_count = 0;
    limit_mirror = CAPACITY;
    acc_len = 0;
    acc_long = 0;
    for (int w = 0; w < NAME_WORDS; w++) acc[w] = '0;
    for (int i = 0; i < CAPACITY; i++) store[i].v = 0;

    repeat (7) @(posedge clk);
    rst <= 0;

    rows.push_back(mk(REQ_LOOKUP, 5, 0, 0, 64'h61, 1, 0, 0, ST_ABSENT, 0, 0));
    rows.push_back(mk(REQ_ENTER, 5, 7, 1, 64'h61, 1, 0, 0, ST_DONE, 0, 1));
    // bytes above chunk_len are junk and must be ignored
    rows.push_back(mk(REQ_LOOKUP, 5, 0, 0, 64'hDEAD_BEEF_FFFF_FF61, 1, 0, 0,
                      ST_FOUND, 7, 1));
    rows.push_back(mk(REQ_ENTER, 5, 0, 1, 64'h62, 1, 0, 0, ST_DONE, 0, 2));
    rows.push_back(mk(REQ_LOOKUP, 5, 0, 0, 64'h62, 1, 0, 0, ST_NEG, 0, 2));
    // existing key: target replaced, count unchanged
    rows.push_back(mk(REQ_ENTER, 5, 9, 3, 64'h61, 1, 0, 0, ST_DONE, 0, 2));
    rows.push_back(mk(REQ_LOOKUP, 5, 0, 0, 64'h61, 1, 0, 0, ST_FOUND, 9, 2));
    // oversize chunk_len is clipped to eight bytes
    rows.push_back(mk(REQ_ENTER, '1, '1, '1, ONES, 15, 1, 15, ST_DONE, 0, 3));
    rows.push_back(mk(REQ_LOOKUP, '1, 0, 0, ONES, 8, 1, 8, ST_FOUND, '1, 3));
    rows.push_back(mk(REQ_ENTER, 0, 3, 2, 0, 0, 0, 0, ST_DONE, 0, 4));
    // zero directory never matches a mount purge
    rows.push_back(mk(REQ_PMOUNT, 0, 0, 2, ONES, 3, 0, 0, ST_DONE, 0, 4));
    // vnode zero takes negative entries and directory zero
    rows.push_back(mk(REQ_PVNODE, 0, 0, 0, ONES, 8, 0, 0, ST_DONE, 0, 2));
    rows.push_back(mk(REQ_PMOUNT, 0, 0, '1, 0, 0, 0, 0, ST_DONE, 0, 1));
    // 256 bytes: too long for both enter and lookup
    rows.push_back(mk(REQ_ENTER, 6, 1, 4, ONES, 8, 31, 8, ST_DONE, 0, 1));
    rows.push_back(mk(REQ_LOOKUP, 6, 0, 0, ONES, 8, 31, 8, ST_ABSENT, 0, 1));
    // exactly 255 bytes still fits
    rows.push_back(mk(REQ_ENTER, 6, 1, 4, ONES, 7, 31, 8, ST_DONE, 0, 2));
    rows.push_back(mk(REQ_LOOKUP, 6, 0, 0, ONES, 7, 31, 8, ST_FOUND, 1, 2));
    rows.push_back(mk(REQ_PVNODE, 0, 1, 0, 0, 0, 0, 0, ST_DONE, 0, 1));

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++) begin
        b = rows[i].b;
        b.last = 0;
        b.clen = rows[i].rep_len;
        send_beat(b, has, r);
      end
      send_beat(rows[i].b, has, r);
      if (rows[i].typed && r != rows[i].r)
        report($sformatf("directed row %0d predicted %p, table says %p", i, r, rows[i].r));
    end

    random_phase(150);
    lims = '{4, 0, 1, 256, 0};
    lims[4] = $urandom_range(2, 40);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_limit(lims[p]);
      quiet = (p == 1);
      random_phase(p == 3 ? 120 : 170);
    end
    quiet = 0;

    // fill past capacity so inserts evict at the store size, then sweep by mount
    drain();
    write_limit(CAPACITY);
    fill_mnt = 16'($urandom_range(1, 65535));
    for (int k = 0; k < 280; k++) begin
      nm = {byte'($urandom)};
      issue(REQ_ENTER, 32'h1000_0000 + k, $urandom, fill_mnt, nm);
    end
    for (int k = 0; k < 10; k++) begin
      nm = {byte'($urandom)};
      issue(REQ_LOOKUP, 32'h1000_0000 + $urandom_range(0, 279), 0, 0, nm);
    end
    nm = {};
    issue(REQ_PMOUNT, 0, 0, fill_mnt, nm);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("directory_name_lru_cache_tb: PASS");
    else
      $display("directory_name_lru_cache_tb: FAIL");
    $finish;
  end
endmodule
